>>> hw/rtl/smdc_pkg.sv
// ============================================================================
// smdc_pkg: shared types and constants
// Field widths, register width, control state codes and the control
// group that steers the sorted cell row.
// ============================================================================
package smdc_pkg;

   // Fixed field widths at the block ports.
   localparam int DATA_BITS = 32;
   localparam int COST_BITS = 38;
   localparam int CSR_BITS  = 7;

   // Control sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_MEDIAN,
      ST_SUM
   } state_type;

   // Control broadcast to every cell of the sorted row.
   typedef struct packed {
      logic update;   // load the next sorted value this cycle
      logic remove;   // the window is full, drop the oldest sample
      logic flush;    // empty the row
   } cell_ctrl_type;

endpackage

>>> hw/rtl/sliding_median_deviation_cost_core.sv
// ============================================================================
// sliding_median_deviation_cost_core: sliding window median and cost
// Keeps the last window_size samples in a ring RAM (arrival order) and in a
// row of sorted cells. Once the window is full, each sample yields the
// median (rank window_size/2) and the sum of absolute deviations from it.
//
//   port group  direction  flow control    word
//   req_*       in         valid / stall   sample
//   rsp_*       out        valid / stall   median, cost
//   csr_*       in         valid / ready   window_size (flushes the window)
//
// While the window is filling, a sample is accepted (and the oldest word read
// from the ring RAM) and then the cell row is updated. A sample that yields a
// result goes through update, median select, then the registered adder tree.
// Reset clears the sequencer, counters and cell flags; window_size -> min(WINDOW_DEPTH, 64).
// A new sample is taken while the previous result waits in rsp; the block
// only waits on rsp_stall when a second result is ready.
// ============================================================================
module sliding_median_deviation_cost_core
   import smdc_pkg::*;
#(
   parameter int WINDOW_DEPTH = 64,
   parameter int SAMPLE_BITS  = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [DATA_BITS-1:0] req_sample,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [DATA_BITS-1:0] rsp_median,
   output logic [COST_BITS-1:0] rsp_cost,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_BITS-1:0]  csr_window_size
);

   localparam int CntBits   = $clog2(WINDOW_DEPTH + 1);
   localparam int AddrBits  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int Levels    = $clog2(WINDOW_DEPTH);
   localparam int Leaves    = 1 << Levels;
   localparam int SumWait   = Levels + 1;
   localparam int WaitBits  = $clog2(SumWait + 1);
   localparam int InBits    = (SAMPLE_BITS > DATA_BITS) ? SAMPLE_BITS : DATA_BITS;
   localparam int ResetSize = (WINDOW_DEPTH < 64) ? WINDOW_DEPTH : 64;

   state_type              state_ff, state_in;
   logic [CntBits-1:0]     size_ff, size_in;
   logic [CntBits-1:0]     fill_ff, fill_in;
   logic [AddrBits-1:0]    oldest_ff, oldest_in;
   logic                   full_ff, full_in;
   logic [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic [SAMPLE_BITS-1:0] median_ff, median_in;
   logic [WaitBits-1:0]    wait_ff, wait_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DATA_BITS-1:0]   rsp_median_ff, rsp_median_in;
   logic [COST_BITS-1:0]   rsp_cost_ff, rsp_cost_in;

   logic                   req_take, csr_take, rsp_free;
   logic [CntBits-1:0]     size_eff;
   logic [InBits-1:0]      req_ext, median_ext;
   logic [SAMPLE_BITS-1:0] old_value;
   logic                   ram_wr_en, ram_rd_en;
   logic [AddrBits-1:0]    ram_wr_addr;
   logic [CntBits-1:0]     half;
   cell_ctrl_type          cell_ctrl;

   logic [SAMPLE_BITS-1:0] cell_value [WINDOW_DEPTH];
   logic [SAMPLE_BITS-1:0] cell_shift [WINDOW_DEPTH];
   logic [COST_BITS-1:0]   cell_dev   [WINDOW_DEPTH];
   logic [WINDOW_DEPTH-1:0] cell_valid, cell_shift_valid, cell_greater;
   logic [COST_BITS-1:0]   leaf [Leaves];
   logic [COST_BITS-1:0]   total;

   // Handshakes.
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign csr_take  = csr_valid && csr_ready;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // Window size as used: zero means one, above the depth saturates.
   always_comb begin
      if (csr_window_size == '0) begin
         size_eff = CntBits'(1);
      end else if (int'(csr_window_size) > WINDOW_DEPTH) begin
         size_eff = CntBits'(WINDOW_DEPTH);
      end else begin
         size_eff = CntBits'(csr_window_size);
      end
   end

   // Sample resized to the internal width (zero-extended or truncated).
   assign req_ext   = InBits'(req_sample);
   assign sample_in = req_take ? req_ext[SAMPLE_BITS-1:0] : sample_ff;

   // Arrival ring: read the oldest word on accept, write the new one on update.
   assign ram_rd_en   = req_take;
   assign ram_wr_en   = (state_ff == ST_UPDATE);
   assign ram_wr_addr = full_ff ? oldest_ff : AddrBits'(fill_ff);

   smdc_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (WINDOW_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (sample_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (oldest_ff),
      .rd_data (old_value)
   );

   // Sorted cell row.
   assign cell_ctrl.update = (state_ff == ST_UPDATE);
   assign cell_ctrl.remove = full_ff;
   assign cell_ctrl.flush  = csr_take;

   for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
      logic [SAMPLE_BITS-1:0] left_value, right_value;
      logic                   left_valid, left_greater, right_valid;

      if (i == 0) begin : g_first
         assign left_value   = '0;
         assign left_valid   = 1'b0;
         assign left_greater = 1'b0;
      end else begin : g_inner_left
         assign left_value   = cell_shift[i-1];
         assign left_valid   = cell_shift_valid[i-1];
         assign left_greater = cell_greater[i-1];
      end

      if (i == WINDOW_DEPTH - 1) begin : g_last
         assign right_value = '0;
         assign right_valid = 1'b0;
      end else begin : g_inner_right
         assign right_value = cell_value[i+1];
         assign right_valid = cell_valid[i+1];
      end

      smdc_cell #(
         .SAMPLE_BITS (SAMPLE_BITS)
      ) u_cell (
         .clock            (clock),
         .reset            (reset),
         .ctrl             (cell_ctrl),
         .old_value        (old_value),
         .new_value        (sample_ff),
         .median           (median_ff),
         .left_shift_value (left_value),
         .left_shift_valid (left_valid),
         .left_greater     (left_greater),
         .right_value      (right_value),
         .right_valid      (right_valid),
         .value            (cell_value[i]),
         .valid            (cell_valid[i]),
         .shift_value      (cell_shift[i]),
         .shift_valid      (cell_shift_valid[i]),
         .greater          (cell_greater[i]),
         .deviation        (cell_dev[i])
      );
   end

   // Median select: the slot whose position is half the window size.
   assign half = size_ff >> 1;

   always_comb begin
      median_in = median_ff;
      if (state_ff == ST_MEDIAN) begin
         median_in = '0;
         for (int i = 0; i < WINDOW_DEPTH; i++) begin
            if (CntBits'(i) == half) begin
               median_in = cell_value[i];
            end
         end
      end
   end

   // Deviation sum over the row, padded to a power of two.
   always_comb begin
      for (int j = 0; j < Leaves; j++) begin
         leaf[j] = (j < WINDOW_DEPTH) ? cell_dev[j] : '0;
      end
   end

   smdc_sum_tree #(
      .LEVELS (Levels)
   ) u_tree (
      .clock (clock),
      .leaf  (leaf),
      .total (total)
   );

   // Sequencer, counters and result register.
   assign median_ext = InBits'(median_ff);

   always_comb begin
      state_in      = state_ff;
      size_in       = size_ff;
      fill_in       = fill_ff;
      oldest_in     = oldest_ff;
      full_in       = full_ff;
      wait_in       = wait_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_median_in = rsp_median_ff;
      rsp_cost_in   = rsp_cost_ff;

      case (state_ff)
         ST_IDLE: begin
            if (csr_take) begin
               size_in   = size_eff;
               fill_in   = '0;
               oldest_in = '0;
            end
            // A word taken with a size write lands in the freshly emptied window.
            if (req_take) begin
               full_in  = csr_take ? 1'b0 : (fill_ff == size_ff);
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (full_ff) begin
               if (CntBits'(oldest_ff) == size_ff - CntBits'(1)) begin
                  oldest_in = '0;
               end else begin
                  oldest_in = oldest_ff + AddrBits'(1);
               end
               state_in = ST_MEDIAN;
            end else begin
               fill_in  = fill_ff + CntBits'(1);
               state_in = (fill_ff + CntBits'(1) == size_ff) ? ST_MEDIAN : ST_IDLE;
            end
         end
         ST_MEDIAN: begin
            wait_in  = '0;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            if (wait_ff == WaitBits'(SumWait)) begin
               if (rsp_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_median_in = median_ext[DATA_BITS-1:0];
                  rsp_cost_in   = total;
                  state_in      = ST_IDLE;
               end
            end else begin
               wait_in = wait_ff + WaitBits'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         size_ff      <= CntBits'(ResetSize);
         fill_ff      <= '0;
         oldest_ff    <= '0;
         full_ff      <= 1'b0;
         wait_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         fill_ff      <= fill_in;
         oldest_ff    <= oldest_in;
         full_ff      <= full_in;
         wait_ff      <= wait_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff     <= sample_in;
      median_ff     <= median_in;
      rsp_median_ff <= rsp_median_in;
      rsp_cost_ff   <= rsp_cost_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_median = rsp_median_ff;
   assign rsp_cost   = rsp_cost_ff;

   // The fill count never passes the window size.
   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      fill_ff <= size_ff)
      else $error("fill count above window size");

   // Between items the row holds exactly as many words as the fill count.
   a_row_count : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> ($countones(cell_valid) == int'(fill_ff)))
      else $error("sorted row occupancy differs from fill count");

   // A new result appears only at the end of the deviation sum.
   a_rsp_source : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && rsp_stall)) |-> $past(state_ff == ST_SUM))
      else $error("result loaded outside the sum phase");

   // An accepted word always goes straight into the row update.
   a_accept_update : assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ST_UPDATE))
      else $error("accepted word did not start an update");

endmodule

>>> hw/rtl/smdc_ram.sv
// ============================================================================
// smdc_ram: generic single-port-write, registered-read RAM
// One write and one read per cycle; read data is registered.
// ============================================================================
module smdc_ram #(
   parameter  int WIDTH    = 32,
   parameter  int DEPTH    = 64,
   localparam int AddrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AddrBits-1:0] wr_addr,
   input  logic [WIDTH-1:0]    wr_data,
   input  logic                rd_en,
   input  logic [AddrBits-1:0] rd_addr,
   output logic [WIDTH-1:0]    rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Storage array and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/smdc_cell.sv
// ============================================================================
// smdc_cell: one slot of the sorted window
// Holds one sample and its valid flag. In an update cycle it drops the
// oldest word if the window is full (shift in from the right), makes room
// for the new word (shift in from the left), using its neighbors' state.
// ============================================================================
module smdc_cell
   import smdc_pkg::*;
#(
   parameter int SAMPLE_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cell_ctrl_type          ctrl,
   input  logic [SAMPLE_BITS-1:0] old_value,
   input  logic [SAMPLE_BITS-1:0] new_value,
   input  logic [SAMPLE_BITS-1:0] median,
   input  logic [SAMPLE_BITS-1:0] left_shift_value,
   input  logic                   left_shift_valid,
   input  logic                   left_greater,
   input  logic [SAMPLE_BITS-1:0] right_value,
   input  logic                   right_valid,
   output logic [SAMPLE_BITS-1:0] value,
   output logic                   valid,
   output logic [SAMPLE_BITS-1:0] shift_value,
   output logic                   shift_valid,
   output logic                   greater,
   output logic [COST_BITS-1:0]   deviation
);

   localparam int DevBits = (SAMPLE_BITS > COST_BITS) ? SAMPLE_BITS : COST_BITS;

   logic [SAMPLE_BITS-1:0] value_ff, value_in;
   logic                   valid_ff, valid_in;
   logic                   drop;
   logic [SAMPLE_BITS-1:0] diff;
   logic [DevBits-1:0]     diff_ext;

   // Removal step: every valid slot at or above the oldest word takes its
   // right neighbor, which deletes the first copy of that word.
   assign drop        = ctrl.remove && valid_ff && (value_ff >= old_value);
   assign shift_value = drop ? right_value : value_ff;
   assign shift_valid = drop ? right_valid : valid_ff;

   // Insertion step: an empty slot counts as larger than any sample.
   assign greater = !shift_valid || (shift_value > new_value);

   always_comb begin
      if (left_greater) begin
         value_in = left_shift_value;
         valid_in = left_shift_valid;
      end else if (greater) begin
         value_in = new_value;
         valid_in = 1'b1;
      end else begin
         value_in = shift_value;
         valid_in = shift_valid;
      end
   end

   // Slot registers; the flag is cleared by reset and by a flush.
   always_ff @(posedge clock) begin
      if (reset || ctrl.flush) begin
         valid_ff <= 1'b0;
      end else if (ctrl.update) begin
         valid_ff <= valid_in;
      end
      if (ctrl.update) begin
         value_ff <= value_in;
      end
   end

   // Absolute deviation from the median; empty slots contribute nothing.
   assign diff      = (value_ff >= median) ? (value_ff - median) : (median - value_ff);
   assign diff_ext  = DevBits'(diff);
   assign deviation = valid_ff ? diff_ext[COST_BITS-1:0] : '0;

   assign value = value_ff;
   assign valid = valid_ff;

endmodule

>>> hw/rtl/smdc_sum_tree.sv
// ============================================================================
// smdc_sum_tree: registered binary adder tree
// Sums 2**LEVELS leaves modulo 2**COST_BITS with one register per level.
// ============================================================================
module smdc_sum_tree
   import smdc_pkg::*;
#(
   parameter  int LEVELS = 6,
   localparam int Leaves = 1 << LEVELS
) (
   input  logic                 clock,
   input  logic [COST_BITS-1:0] leaf [Leaves],
   output logic [COST_BITS-1:0] total
);

   localparam int Nodes = 2 * Leaves - 1;

   logic [COST_BITS-1:0] node_ff [Nodes];
   logic [COST_BITS-1:0] node_in [Nodes];

   // Heap layout: node k adds children 2k+1 and 2k+2, leaves at the end.
   always_comb begin
      for (int k = 0; k < Leaves - 1; k++) begin
         node_in[k] = node_ff[2*k+1] + node_ff[2*k+2];
      end
      for (int j = 0; j < Leaves; j++) begin
         node_in[Leaves-1+j] = leaf[j];
      end
   end

   always_ff @(posedge clock) begin
      node_ff <= node_in;
   end

   assign total = node_ff[0];

endmodule
